// File: src/ft12_pkg.sv
// ============================================================================
// ft12_pkg
// Shared types and constants for the FAT12 table engine: opcodes, status
// codes, entry markers and the command and status bundles that pass between
// the controller and the datapath.
// ============================================================================
package ft12_pkg;

   // Entry markers of a FAT12 table.
   localparam logic [11:0] END_MARK = 12'hFFF;
   localparam logic [11:0] BAD_MARK = 12'hFF7;

   // Request opcodes.
   typedef enum logic [2:0] {
      OP_RD_ENTRY = 3'd0,
      OP_WR_ENTRY = 3'd1,
      OP_RD_BYTE  = 3'd2,
      OP_WR_BYTE  = 3'd3,
      OP_FIND     = 3'd4,
      OP_EXTEND   = 3'd5
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Memory port operations.
   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_RD_LO,
      MEM_RD_HI,
      MEM_WR_LO,
      MEM_WR_HI,
      MEM_RD_BYTE,
      MEM_WR_BYTE,
      MEM_CLR
   } mem_op_type;

   // Source of the entry index that the memory port addresses.
   typedef enum logic [2:0] {
      TGT_KEEP,
      TGT_IDX,
      TGT_SCAN,
      TGT_CUR,
      TGT_ENT,
      TGT_FOUND
   } tgt_sel_type;

   // Source of the 12-bit value stored by an entry write.
   typedef enum logic [1:0] {
      WV_REQ,
      WV_FOUND,
      WV_END
   } wval_sel_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic         load_req;
      logic         clr_wr;
      mem_op_type   mem_op;
      tgt_sel_type  tgt_sel;
      wval_sel_type wval_sel;
      logic         latch_lo;
      logic         latch_ent;
      logic         scan_init;
      logic         scan_inc;
      logic         step_inc;
      logic         cur_from_ent;
      logic         found_from_scan;
      logic         set_st;
      status_type   st;
      logic         eout_cur;
      logic         eout_ent;
      logic         byte_latch;
      logic         push;
   } ctl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic   clr_last;
      op_type op;
      logic   idx_oob;
      logic   addr_oob;
      logic   ent_end;
      logic   ent_bad;
      logic   ent_link_bad;
      logic   ent_zero;
      logic   scan_done;
      logic   step_last;
   } dp_stat_type;

endpackage

// File: src/ft12_channels.sv
// ============================================================================
// ft12 channel interfaces
// Valid/ready channels for request beats into and result beats out of the
// FAT12 table engine.
// ============================================================================
interface ft12_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [11:0] entry_index;
   logic [11:0] entry_value;
   logic [12:0] byte_address;
   logic [7:0]  byte_value;

   modport source (output valid, opcode, entry_index, entry_value, byte_address,
                   byte_value, input ready);
   modport sink (input valid, opcode, entry_index, entry_value, byte_address,
                 byte_value, output ready);
endinterface

interface ft12_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] entry_out;
   logic [7:0]  byte_out;
   logic [11:0] found_index;
   logic [1:0]  status;

   modport source (output valid, entry_out, byte_out, found_index, status,
                   input ready);
   modport sink (input valid, entry_out, byte_out, found_index, status,
                 output ready);
endinterface

// File: src/ft12_datapath.sv
// ============================================================================
// ft12_datapath
// Packed table memory, entry assembly and nibble merge, walk and scan
// counters, the size register and the result beat register.
// ============================================================================
module ft12_datapath
   import ft12_pkg::*;
#(
   parameter int NUM_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic [2:0]  req_opcode,
   input  logic [11:0] req_entry_index,
   input  logic [11:0] req_entry_value,
   input  logic [12:0] req_byte_address,
   input  logic [7:0]  req_byte_value,
   output logic [11:0] rsp_entry_out,
   output logic [7:0]  rsp_byte_out,
   output logic [11:0] rsp_found_index,
   output logic [1:0]  rsp_status
);

   localparam int          TBL_BYTES = (NUM_ENTRIES * 3) / 2;
   localparam int          AW        = $clog2(TBL_BYTES);
   localparam logic [12:0] TBL_SIZE  = 13'(TBL_BYTES);
   localparam logic [12:0] LIM_MAX   = 13'(NUM_ENTRIES);

   logic [7:0]  tbl_mem [TBL_BYTES];
   logic [7:0]  rd_data_ff;

   logic [12:0] cfg_ff, lim;
   logic [AW-1:0] clr_ff;
   logic [2:0]  op_ff;
   logic [11:0] idx_ff, val_ff;
   logic [12:0] baddr_ff;
   logic [7:0]  bval_ff;
   logic [11:0] tgt_ff, tgt_in;
   logic [11:0] cur_ff, found_ff, ent_ff;
   logic [7:0]  lo_ff, hi_ff;
   logic [12:0] scan_ff, steps_ff;
   logic [11:0] eout_ff;
   logic [7:0]  bout_ff;
   status_type  st_ff;
   logic [11:0] rsp_eout_ff, rsp_found_ff;
   logic [7:0]  rsp_bout_ff;
   logic [1:0]  rsp_st_ff;

   logic [12:0] off, addr_sel;
   logic [11:0] wval;
   logic [7:0]  wdata;
   logic        mem_we, mem_re;

   // Effective size: the register clipped to the table depth.
   assign lim = (cfg_ff > LIM_MAX) ? LIM_MAX : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= 13'd3072;
      end else if (csr_wr_en) begin
         cfg_ff <= csr_wr_data;
      end
   end

   // Clearing pass address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Byte offset of the addressed entry's first byte.
   assign off = 13'(tgt_ff) + 13'(tgt_ff[11:1]);

   always_comb begin
      case (cmd.wval_sel)
         WV_FOUND: wval = found_ff;
         WV_END:   wval = END_MARK;
         default:  wval = val_ff;
      endcase
   end

   // Memory address and write data, with nibble merge into the shared byte.
   always_comb begin
      addr_sel = off;
      wdata    = 8'h00;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      case (cmd.mem_op)
         MEM_RD_LO: begin
            mem_re = 1'b1;
         end
         MEM_RD_HI: begin
            addr_sel = off + 13'd1;
            mem_re   = 1'b1;
         end
         MEM_WR_LO: begin
            mem_we = 1'b1;
            wdata  = tgt_ff[0] ? {wval[3:0], lo_ff[3:0]} : wval[7:0];
         end
         MEM_WR_HI: begin
            addr_sel = off + 13'd1;
            mem_we   = 1'b1;
            wdata    = tgt_ff[0] ? wval[11:4] : {hi_ff[7:4], wval[11:8]};
         end
         MEM_RD_BYTE: begin
            addr_sel = baddr_ff;
            mem_re   = 1'b1;
         end
         MEM_WR_BYTE: begin
            addr_sel = baddr_ff;
            mem_we   = 1'b1;
            wdata    = bval_ff;
         end
         MEM_CLR: begin
            addr_sel = 13'(clr_ff);
            mem_we   = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      if (cmd.clr_wr) begin
         addr_sel = 13'(clr_ff);
         wdata    = 8'h00;
         mem_we   = 1'b1;
      end
   end

   // Single-port table memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[addr_sel[AW-1:0]] <= wdata;
      end
      if (mem_re) begin
         rd_data_ff <= tbl_mem[addr_sel[AW-1:0]];
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_opcode;
         idx_ff   <= req_entry_index;
         val_ff   <= req_entry_value;
         baddr_ff <= req_byte_address;
         bval_ff  <= req_byte_value;
      end
   end

   always_comb begin
      case (cmd.tgt_sel)
         TGT_IDX:   tgt_in = idx_ff;
         TGT_SCAN:  tgt_in = scan_ff[11:0];
         TGT_CUR:   tgt_in = cur_ff;
         TGT_ENT:   tgt_in = ent_ff;
         TGT_FOUND: tgt_in = found_ff;
         default:   tgt_in = tgt_ff;
      endcase
   end

   // Entry assembly, walk position, scan and step counters.
   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      if (cmd.latch_lo) begin
         lo_ff <= rd_data_ff;
      end
      if (cmd.latch_ent) begin
         hi_ff  <= rd_data_ff;
         ent_ff <= tgt_ff[0] ? {rd_data_ff, lo_ff[7:4]} : {rd_data_ff[3:0], lo_ff};
      end
      if (cmd.load_req) begin
         cur_ff <= req_entry_index;
      end else if (cmd.cur_from_ent) begin
         cur_ff <= ent_ff;
      end
      if (cmd.load_req) begin
         steps_ff <= '0;
      end else if (cmd.step_inc) begin
         steps_ff <= steps_ff + 13'd1;
      end
      if (cmd.scan_init) begin
         scan_ff <= 13'd2;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + 13'd1;
      end
   end

   // Working result fields.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         found_ff <= '0;
         eout_ff  <= '0;
         bout_ff  <= '0;
         st_ff    <= ST_OK;
      end else begin
         if (cmd.found_from_scan) begin
            found_ff <= scan_ff[11:0];
         end
         if (cmd.eout_cur) begin
            eout_ff <= cur_ff;
         end else if (cmd.eout_ent) begin
            eout_ff <= ent_ff;
         end
         if (cmd.byte_latch) begin
            bout_ff <= rd_data_ff;
         end
         if (cmd.set_st) begin
            st_ff <= cmd.st;
         end
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_eout_ff  <= eout_ff;
         rsp_bout_ff  <= bout_ff;
         rsp_found_ff <= found_ff;
         rsp_st_ff    <= st_ff;
      end
   end

   assign rsp_entry_out   = rsp_eout_ff;
   assign rsp_byte_out    = rsp_bout_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_status      = rsp_st_ff;

   // Status back to the controller.
   assign stat.clr_last     = (clr_ff == AW'(TBL_BYTES - 1));
   assign stat.op           = op_type'(op_ff);
   assign stat.idx_oob      = ({1'b0, idx_ff} >= lim);
   assign stat.addr_oob     = (baddr_ff >= TBL_SIZE);
   assign stat.ent_end      = (ent_ff == END_MARK);
   assign stat.ent_bad      = (ent_ff == BAD_MARK);
   assign stat.ent_link_bad = (ent_ff < 12'd2) || ({1'b0, ent_ff} >= lim);
   assign stat.ent_zero     = (ent_ff == 12'd0);
   assign stat.scan_done    = (scan_ff >= lim);
   assign stat.step_last    = ((steps_ff + 13'd1) >= lim);

endmodule

// File: src/ft12_controller.sv
// ============================================================================
// ft12_controller
// Sequencer for the FAT12 table engine: clearing pass, request dispatch,
// entry read and merge-write steps, chain walk, free scan and result beat.
// ============================================================================
module ft12_controller
   import ft12_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [11:0] {
      S_CLEAR     = 12'b000000000001,
      S_IDLE      = 12'b000000000010,
      S_DISPATCH  = 12'b000000000100,
      S_RD_LO     = 12'b000000001000,
      S_RD_HI     = 12'b000000010000,
      S_EVAL      = 12'b000000100000,
      S_ACT       = 12'b000001000000,
      S_SCAN_CHK  = 12'b000010000000,
      S_WR_LO     = 12'b000100000000,
      S_WR_HI     = 12'b001000000000,
      S_BYTE_WAIT = 12'b010000000000,
      S_FINISH    = 12'b100000000000
   } state_type;

   typedef enum logic [2:0] {
      PH_ENTRY,
      PH_WALK,
      PH_SCAN,
      PH_LINK,
      PH_MARK
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_ENTRY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // The stored value follows the step that the write belongs to.
      case (phase_ff)
         PH_LINK: cmd.wval_sel = WV_FOUND;
         PH_MARK: cmd.wval_sel = WV_END;
         default: cmd.wval_sel = WV_REQ;
      endcase

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op) inside
               OP_RD_ENTRY, OP_WR_ENTRY, OP_EXTEND: begin
                  if (stat.idx_oob) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_RANGE;
                     state_in   = S_FINISH;
                  end else begin
                     phase_in    = (stat.op == OP_EXTEND) ? PH_WALK : PH_ENTRY;
                     cmd.tgt_sel = TGT_IDX;
                     state_in    = S_RD_LO;
                  end
               end
               OP_RD_BYTE, OP_WR_BYTE: begin
                  if (stat.addr_oob) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_RANGE;
                     state_in   = S_FINISH;
                  end else if (stat.op == OP_RD_BYTE) begin
                     cmd.mem_op = MEM_RD_BYTE;
                     state_in   = S_BYTE_WAIT;
                  end else begin
                     cmd.mem_op = MEM_WR_BYTE;
                     state_in   = S_FINISH;
                  end
               end
               OP_FIND: begin
                  phase_in      = PH_SCAN;
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN_CHK;
               end
               default: begin
                  cmd.set_st = 1'b1;
                  cmd.st     = ST_RANGE;
                  state_in   = S_FINISH;
               end
            endcase
         end
         S_RD_LO: begin
            cmd.mem_op = MEM_RD_LO;
            state_in   = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.mem_op   = MEM_RD_HI;
            cmd.latch_lo = 1'b1;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            cmd.latch_ent = 1'b1;
            state_in      = S_ACT;
         end
         S_ACT: begin
            case (phase_ff)
               PH_WALK: begin
                  if (stat.ent_end) begin
                     // End of chain reached: look for the new cluster.
                     cmd.eout_cur  = 1'b1;
                     cmd.scan_init = 1'b1;
                     phase_in      = PH_SCAN;
                     state_in      = S_SCAN_CHK;
                  end else if (stat.ent_bad) begin
                     cmd.eout_cur = 1'b1;
                     cmd.set_st   = 1'b1;
                     cmd.st       = ST_BAD;
                     state_in     = S_FINISH;
                  end else if (stat.ent_link_bad) begin
                     cmd.eout_cur = 1'b1;
                     cmd.set_st   = 1'b1;
                     cmd.st       = ST_RANGE;
                     state_in     = S_FINISH;
                  end else if (stat.step_last) begin
                     // Chain loop guard.
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_RANGE;
                     state_in   = S_FINISH;
                  end else begin
                     cmd.step_inc     = 1'b1;
                     cmd.cur_from_ent = 1'b1;
                     cmd.tgt_sel      = TGT_ENT;
                     state_in         = S_RD_LO;
                  end
               end
               PH_SCAN: begin
                  if (stat.ent_zero) begin
                     cmd.found_from_scan = 1'b1;
                     if (stat.op == OP_EXTEND) begin
                        phase_in    = PH_LINK;
                        cmd.tgt_sel = TGT_CUR;
                        state_in    = S_RD_LO;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end else begin
                     cmd.scan_inc = 1'b1;
                     state_in     = S_SCAN_CHK;
                  end
               end
               default: begin
                  if (phase_ff == PH_ENTRY && stat.op == OP_RD_ENTRY) begin
                     cmd.eout_ent = 1'b1;
                     state_in     = S_FINISH;
                  end else begin
                     state_in = S_WR_LO;
                  end
               end
            endcase
         end
         S_SCAN_CHK: begin
            if (stat.scan_done) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_FULL;
               state_in   = S_FINISH;
            end else begin
               cmd.tgt_sel = TGT_SCAN;
               state_in    = S_RD_LO;
            end
         end
         S_WR_LO: begin
            cmd.mem_op = MEM_WR_LO;
            state_in   = S_WR_HI;
         end
         S_WR_HI: begin
            cmd.mem_op = MEM_WR_HI;
            if (phase_ff == PH_LINK) begin
               // Last entry linked; now mark the new entry as chain end.
               phase_in    = PH_MARK;
               cmd.tgt_sel = TGT_FOUND;
               state_in    = S_RD_LO;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BYTE_WAIT: begin
            cmd.byte_latch = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

`ifndef SYNTHESIS
   // A result beat is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten while pending");

   // An accepted request beat always starts dispatch in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted request not dispatched");

   // A new result beat appears only out of the finish state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result beat raised outside finish");

   // Memory writes from a request never overlap the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> (cmd.mem_op == MEM_NONE))
      else $error("memory command during clearing pass");
`endif

endmodule

// File: src/fat12_table_engine.sv
// ============================================================================
// fat12_table_engine
// FAT12 allocation table kept as a packed byte image, with entry access,
// raw byte access, free search and chain extension.
// ============================================================================
// Usage:
//   req_chan carries one command per beat (opcode, entry index and value, byte
//   address and value); rsp_chan returns exactly one result beat per command.
//   csr_wr_en with csr_wr_data sets entries_in_use; write it only while idle.
// Datapath: all commands go through one single-port byte memory with a
//   registered read. A chain step is two byte reads, assemble and decide;
//   a scanned entry adds a scan check. Extend walks the chain, scans for a
//   free entry and then makes two read-merge-write passes. Out-of-range and
//   unknown commands go from dispatch straight to the result.
// Throughput: one command at a time; the next request is taken as soon as the
//   current result is placed in the output register.
// Reset: the table is cleared by a pass over its 1.5*NUM_ENTRIES bytes (6144
//   at the default), one byte per cycle, with req ready low; the size
//   register goes to 3072.
// Stall: a result beat waits in the output register while rsp ready is low;
//   a following command runs and holds its result until the register frees.
// ============================================================================
module fat12_table_engine
   import ft12_pkg::*;
#(
   parameter int NUM_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   ft12_req_if.sink    req_chan,
   ft12_rsp_if.source  rsp_chan
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // Sequencer.
   ft12_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table memory and datapath.
   ft12_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_chan.opcode),
      .req_entry_index  (req_chan.entry_index),
      .req_entry_value  (req_chan.entry_value),
      .req_byte_address (req_chan.byte_address),
      .req_byte_value   (req_chan.byte_value),
      .rsp_entry_out    (rsp_chan.entry_out),
      .rsp_byte_out     (rsp_chan.byte_out),
      .rsp_found_index  (rsp_chan.found_index),
      .rsp_status       (rsp_chan.status)
   );

endmodule

// File: tb/tb_fat12_table_engine.sv
// ============================================================================
// tb_fat12_table_engine
// Self-checking testbench for the FAT12 table engine. Command beats are driven
// from a queue of pending commands, and each accepted command is run through a
// local model of the packed table to predict its result beat. Result beats are
// compared field by field in order. The size register is rewritten between
// phases while the engine is idle, from the smallest sizes up to past the
// table capacity.
// ============================================================================
module tb_fat12_table_engine
   import ft12_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_ENT    = 4096;
   localparam int unsigned TBL_BYTES  = (NUM_ENT * 3) / 2;
   localparam int unsigned CYCLE_CAP  = 200000000;
   localparam logic [2:0]  OP_UNDEF_A = 3'd6;
   localparam logic [2:0]  OP_UNDEF_B = 3'd7;

   typedef struct {
      logic [2:0]  op;
      logic [11:0] idx;
      logic [11:0] val;
      logic [12:0] addr;
      logic [7:0]  bval;
   } fat_cmd_type;

   typedef struct {
      logic [11:0] entry_out;
      logic [7:0]  byte_out;
      logic [11:0] found_index;
      status_type  status;
   } fat_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   ft12_req_if req_bus ();
   ft12_rsp_if rsp_bus ();

   fat12_table_engine dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // Local copy of the table image and the size register.
   logic [7:0]  fat_image [TBL_BYTES];
   int unsigned volume_size;

   fat_cmd_type pending_cmds [$];
   fat_rsp_type awaited_rsps [$];
   int unsigned cmds_queued;
   int unsigned err_count;
   int unsigned cycle_count;
   bit          no_idle;
   int unsigned send_gap;
   int unsigned recv_stall;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Table model
   // ------------------------------------------------------------------------
   function automatic int unsigned active_limit();
      return (volume_size > NUM_ENT) ? NUM_ENT : volume_size;
   endfunction

   function automatic logic [11:0] fat_entry(int unsigned n);
      int unsigned off;
      off = (3 * n) / 2;
      if (n[0])
         return {fat_image[off + 1], fat_image[off][7:4]};
      return {fat_image[off + 1][3:0], fat_image[off]};
   endfunction

   // Nibble merge keeps the neighbor entry that shares the middle byte.
   function automatic void fat_store(int unsigned n, logic [11:0] v);
      int unsigned off;
      off = (3 * n) / 2;
      if (n[0]) begin
         fat_image[off]     = {v[3:0], fat_image[off][3:0]};
         fat_image[off + 1] = v[11:4];
      end else begin
         fat_image[off]     = v[7:0];
         fat_image[off + 1] = {fat_image[off + 1][7:4], v[11:8]};
      end
   endfunction

   function automatic bit first_free(output int unsigned at);
      int unsigned lim;
      lim = active_limit();
      at = 0;
      for (int unsigned i = 2; i < lim; i++) begin
         if (fat_entry(i) == 12'd0) begin
            at = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic fat_rsp_type apply_command(fat_cmd_type c);
      fat_rsp_type r;
      int unsigned lim, cur, steps, f;
      logic [11:0] v;
      bit          walking, ended;
      lim = active_limit();
      r.entry_out = '0;
      r.byte_out = '0;
      r.found_index = '0;
      r.status = ST_OK;
      case (c.op)
         OP_RD_ENTRY: begin
            if (c.idx >= lim) r.status = ST_RANGE;
            else r.entry_out = fat_entry(c.idx);
         end
         OP_WR_ENTRY: begin
            if (c.idx >= lim) r.status = ST_RANGE;
            else fat_store(c.idx, c.val);
         end
         OP_RD_BYTE: begin
            if (c.addr >= TBL_BYTES) r.status = ST_RANGE;
            else r.byte_out = fat_image[c.addr];
         end
         OP_WR_BYTE: begin
            if (c.addr >= TBL_BYTES) r.status = ST_RANGE;
            else fat_image[c.addr] = c.bval;
         end
         OP_FIND: begin
            if (first_free(f)) r.found_index = 12'(f);
            else r.status = ST_FULL;
         end
         OP_EXTEND: begin
            if (c.idx >= lim) begin
               r.status = ST_RANGE;
            end else begin
               // Walk the chain to its end marker, stopping on any defect.
               cur = c.idx;
               steps = 0;
               walking = 1'b1;
               ended = 1'b0;
               while (walking) begin
                  v = fat_entry(cur);
                  if (v == END_MARK) begin
                     ended = 1'b1;
                     walking = 1'b0;
                  end else if (v == BAD_MARK) begin
                     r.status = ST_BAD;
                     r.entry_out = 12'(cur);
                     walking = 1'b0;
                  end else if (v < 2 || v >= lim) begin
                     r.status = ST_RANGE;
                     r.entry_out = 12'(cur);
                     walking = 1'b0;
                  end else begin
                     steps++;
                     if (steps >= lim) begin
                        r.status = ST_RANGE;
                        walking = 1'b0;
                     end else begin
                        cur = v;
                     end
                  end
               end
               if (ended) begin
                  r.entry_out = 12'(cur);
                  if (!first_free(f)) begin
                     r.status = ST_FULL;
                  end else begin
                     r.found_index = 12'(f);
                     fat_store(cur, 12'(f));
                     fat_store(f, END_MARK);
                  end
               end
            end
         end
         default: r.status = ST_RANGE;
      endcase
      return r;
   endfunction

   task automatic flag_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Command driver: one beat per pending command, with random gap bursts.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      fat_cmd_type c;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            c.op = req_bus.opcode;
            c.idx = req_bus.entry_index;
            c.val = req_bus.entry_value;
            c.addr = req_bus.byte_address;
            c.bval = req_bus.byte_value;
            awaited_rsps.push_back(apply_command(c));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.opcode <= c.op;
               req_bus.entry_index <= c.idx;
               req_bus.entry_value <= c.val;
               req_bus.byte_address <= c.addr;
               req_bus.byte_value <= c.bval;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: checks each beat against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      fat_rsp_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_rsps.size() == 0) begin
               flag_error("result beat with no command outstanding");
            end else begin
               e = awaited_rsps.pop_front();
               if (rsp_bus.entry_out !== e.entry_out)
                  flag_error($sformatf("entry_out %h, predicted %h",
                                       rsp_bus.entry_out, e.entry_out));
               if (rsp_bus.byte_out !== e.byte_out)
                  flag_error($sformatf("byte_out %h, predicted %h",
                                       rsp_bus.byte_out, e.byte_out));
               if (rsp_bus.found_index !== e.found_index)
                  flag_error($sformatf("found_index %h, predicted %h",
                                       rsp_bus.found_index, e.found_index));
               if (rsp_bus.status !== e.status)
                  flag_error($sformatf("status %0d, predicted %0d",
                                       rsp_bus.status, e.status));
            end
         end
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            recv_stall <= $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic put(logic [2:0] op, logic [11:0] idx, logic [11:0] val,
                      logic [12:0] addr, logic [7:0] bval);
      fat_cmd_type c;
      c.op = op;
      c.idx = idx;
      c.val = val;
      c.addr = addr;
      c.bval = bval;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // Waits at the falling edge until every command has produced its result.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() > 0 || awaited_rsps.size() > 0 || req_bus.valid);
   endtask

   task automatic set_volume(logic [12:0] size);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      volume_size = size;
      @(negedge clock);
   endtask

   // One command with mostly in-window fields and occasional full-range ones.
   task automatic put_noise(int unsigned win);
      int unsigned pick;
      logic [2:0]  op;
      logic [11:0] idx, val;
      logic [12:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_RD_ENTRY;
      else if (pick < 45) op = OP_WR_ENTRY;
      else if (pick < 55) op = OP_RD_BYTE;
      else if (pick < 63) op = OP_WR_BYTE;
      else if (pick < 75) op = OP_FIND;
      else if (pick < 96) op = OP_EXTEND;
      else op = pick[0] ? OP_UNDEF_A : OP_UNDEF_B;
      idx = ($urandom_range(0, 15) == 0) ? 12'($urandom) : 12'($urandom_range(0, win - 1));
      case ($urandom_range(0, 6))
         0: val = 12'd0;
         1: val = END_MARK;
         2: val = BAD_MARK;
         6: val = 12'($urandom);
         default: val = 12'($urandom_range(0, win - 1));
      endcase
      addr = ($urandom_range(0, 15) == 0) ? 13'($urandom)
                                          : 13'($urandom_range(0, (3 * win) / 2 + 1));
      put(op, idx, val, addr, 8'($urandom));
   endtask

   // A short well-formed chain, sometimes damaged, then an extend from its head.
   task automatic put_chain(int unsigned hi);
      int unsigned len;
      logic [11:0] node [4];
      logic [11:0] link;
      len = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) node[k] = 12'($urandom_range(2, hi));
      for (int k = 0; k < len; k++) begin
         link = (k == len - 1) ? END_MARK : node[k + 1];
         if ($urandom_range(0, 9) == 0) link = ($urandom_range(0, 1) != 0) ? BAD_MARK
                                                                            : 12'($urandom);
         put(OP_WR_ENTRY, node[k], link, 13'($urandom), 8'($urandom));
      end
      put(OP_EXTEND, node[0], 12'($urandom), 13'($urandom), 8'($urandom));
      if ($urandom_range(0, 1) != 0)
         put(OP_RD_ENTRY, node[len - 1], 12'($urandom), 13'($urandom), 8'($urandom));
   endtask

   task automatic run_random(int unsigned count);
      int unsigned lim, win, hi, stop_at;
      lim = active_limit();
      win = (lim + 2 > 48) ? 48 : lim + 2;
      if (win < 3) win = 3;
      hi = ((lim < win) ? lim : win) - 1;
      stop_at = cmds_queued + count;
      while (cmds_queued < stop_at) begin
         if (lim >= 4 && $urandom_range(0, 9) < 6) put_chain(hi);
         else put_noise(win);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.byte_address = '0;
      req_bus.byte_value = '0;
      rsp_bus.ready = 1'b0;
      no_idle = 1'b0;
      cmds_queued = 0;
      err_count = 0;
      cycle_count = 0;
      volume_size = 3072;
      for (int i = 0; i < TBL_BYTES; i++) fat_image[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: entry packing, range edges, markers and undefined opcodes.
      put(OP_RD_ENTRY, 12'd0, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd0, END_MARK, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd1, 12'hABC, 13'd0, 8'd0);
      put(OP_RD_BYTE, 12'd0, 12'd0, 13'd1, 8'd0);
      put(OP_WR_BYTE, 12'd0, 12'd0, 13'd2, 8'hFF);
      put(OP_RD_ENTRY, 12'd1, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd3071, 12'h123, 13'd0, 8'd0);
      put(OP_RD_ENTRY, 12'd3072, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'hFFF, 12'hFFF, 13'd0, 8'd0);
      put(OP_RD_BYTE, 12'd0, 12'd0, 13'd6143, 8'd0);
      put(OP_RD_BYTE, 12'd0, 12'd0, 13'd6144, 8'd0);
      put(OP_WR_BYTE, 12'd0, 12'd0, 13'h1FFF, 8'h5A);
      put(OP_FIND, 12'd0, 12'd0, 13'd0, 8'd0);
      put(OP_EXTEND, 12'd0, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd3, BAD_MARK, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd5, 12'd3, 13'd0, 8'd0);
      put(OP_EXTEND, 12'd5, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd6, 12'd1, 13'd0, 8'd0);
      put(OP_EXTEND, 12'd6, 12'd0, 13'd0, 8'd0);
      put(OP_WR_ENTRY, 12'd7, 12'd7, 13'd0, 8'd0);
      put(OP_EXTEND, 12'd7, 12'd0, 13'd0, 8'd0);
      put(OP_EXTEND, 12'd3072, 12'd0, 13'd0, 8'd0);
      put(OP_UNDEF_A, 12'hFFF, 12'hFFF, 13'h1FFF, 8'hFF);
      put(OP_UNDEF_B, 12'd0, 12'd0, 13'd0, 8'd0);

      // Smallest size: one searchable entry, then none at all.
      set_volume(13'd3);
      put(OP_WR_ENTRY, 12'd2, 12'd9, 13'd0, 8'd0);
      put(OP_FIND, 12'd0, 12'd0, 13'd0, 8'd0);
      run_random(100);
      set_volume(13'd0);
      run_random(60);

      set_volume(13'd16);
      run_random(280);
      set_volume(13'd4096);
      run_random(200);
      set_volume(13'h1FFF);
      run_random(150);
      set_volume(13'd40);
      run_random(300);

      // Final stretch without any idling on either side.
      set_volume(13'd3072);
      no_idle = 1'b1;
      run_random(300);

      wait_idle();
      repeat (20) @(posedge clock);
      if (err_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
